// File: hdl/assert_macros.svh
// Assertion macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When trig holds, cond must hold at the next clock edge.
`define ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: hdl/uld_pkg.sv
// Types, constants and helper functions of the URI list percent decoder.
package uld_pkg;

   localparam int HOST_CHARS = 16;
   localparam int HOST_LIMIT = (HOST_CHARS < 16) ? HOST_CHARS : 16;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [1:0] CSR_HOST_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HOST_SECOND = 2'd1;
   localparam logic [1:0] CSR_HOST_LENGTH = 2'd2;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_PREFIX,
      MODE_HOST,
      MODE_BODY,
      MODE_ESC1,
      MODE_ESC2,
      MODE_SKIP
   } mode_type;

   // Results caused by one input item: prefix flush, optional byte, optional end marker.
   typedef struct packed {
      logic [2:0] pre_start;
      logic [2:0] pre_cnt;
      logic       has_byte;
      logic [7:0] byte_val;
      logic       has_end;
      logic       end_reject;
   } event_type;

   typedef struct packed {
      logic [2:0] pre_start;
      logic [2:0] pre_cnt;
      logic       has_byte;
      logic [7:0] byte_val;
      logic       end_reject;
      logic [2:0] total;
   } group_type;

   // "file:/" one character at a time
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h66;
         3'd1: ch = 8'h69;
         3'd2: ch = 8'h6C;
         3'd3: ch = 8'h65;
         3'd4: ch = 8'h3A;
         3'd5: ch = CHAR_SLASH;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   // bit 4 set when c is a hex digit, value in bits 3:0
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// File: hdl/uri_list_percent_decoder.sv
// URI list percent decoder: splits text into URIs, strips file prefixes, decodes escapes.
//
// Usage
//   req_* carries one text byte per transfer; req_buffer_end marks the last byte of a
//   buffer, after which any open URI is closed. rsp_* carries result items: a decoded
//   byte, or an accept / reject marker at the end of each URI. rsp_run_last flags the
//   last result caused by one input byte. A transfer happens when valid is high and
//   stall is low. csr_* writes the hostname (two 64-bit words, first byte in the low
//   bits) and its length; write only while no results are outstanding.
// Timing
//   An input byte updates the scan state in the cycle it is taken; its results are
//   registered in a two-entry queue of result groups between the scanner and the output
//   and show on rsp_* one per cycle while rsp_stall is low. One byte is taken per cycle
//   as long as each byte makes at most one result and rsp_stall is low. A byte that
//   flushes held prefix bytes makes up to seven results and holds the output for all of
//   them; the input stalls only when both queue entries are occupied.
// Reset
//   Synchronous reset clears the hostname registers, returns the scanner to between
//   URIs and empties the result queue. A stalled receiver freezes rsp_* in place.
module uri_list_percent_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_decoded_byte,
   output logic        rsp_run_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] host_first_ff;
   logic [63:0] host_second_ff;
   logic [4:0]  host_length_ff;
   logic [4:0]  host_len;

   uld_pkg::mode_type mode_ff, mode_in;
   logic [4:0] match_ff, match_in;
   logic [3:0] hex_ff, hex_in;

   uld_pkg::event_type evt;
   uld_pkg::group_type grp_new;
   uld_pkg::group_type grp_ff [2];
   uld_pkg::group_type head;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic [2:0] pos_ff;

   logic req_xfer, rsp_xfer, push, pop;

   assign host_len = (host_length_ff > 5'(uld_pkg::HOST_LIMIT)) ?
                     5'(uld_pkg::HOST_LIMIT) : host_length_ff;

   assign req_stall = (cnt_ff == 2'd2);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         host_first_ff  <= '0;
         host_second_ff <= '0;
         host_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            uld_pkg::CSR_HOST_FIRST:  host_first_ff  <= csr_data;
            uld_pkg::CSR_HOST_SECOND: host_second_ff <= csr_data;
            uld_pkg::CSR_HOST_LENGTH: host_length_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // scanner next state and per-byte events
   always_comb begin : scan_next
      logic [7:0]   c;
      logic         ws;
      logic [4:0]   hx;
      logic [2:0]   pm;
      logic [7:0]   hbyte;
      logic [127:0] host_all;
      logic         run_body, run_host, run_end;
      c        = req_text_byte;
      ws       = uld_pkg::is_space(c);
      hx       = uld_pkg::hex_decode(c);
      pm       = match_ff[2:0];
      hbyte    = 8'h00;
      host_all = {host_second_ff, host_first_ff};
      run_body = 1'b0;
      run_host = 1'b0;
      run_end  = 1'b0;
      mode_in  = mode_ff;
      match_in = match_ff;
      hex_in   = hex_ff;
      evt      = '0;
      evt.byte_val = c;

      if ((mode_in == uld_pkg::MODE_IDLE) && !ws) begin
         mode_in  = uld_pkg::MODE_PREFIX;
         match_in = 5'd0;
      end

      if (mode_in != uld_pkg::MODE_IDLE) begin
         if (ws) begin
            run_end = 1'b1;
         end else begin
            case (mode_in)
               uld_pkg::MODE_PREFIX: begin
                  pm = match_in[2:0];
                  if (pm < 3'd6) begin
                     if (c == uld_pkg::prefix_char(pm)) begin
                        match_in = 5'(pm + 3'd1);
                     end else begin
                        evt.pre_cnt = pm;
                        mode_in     = uld_pkg::MODE_BODY;
                        run_body    = 1'b1;
                     end
                  end else if (pm == 3'd6) begin
                     if (c != uld_pkg::CHAR_SLASH) begin
                        evt.pre_start = 3'd5;
                        evt.pre_cnt   = 3'd1;
                        mode_in       = uld_pkg::MODE_BODY;
                        run_body      = 1'b1;
                     end else begin
                        match_in = 5'd7;
                     end
                  end else begin
                     match_in = 5'd0;
                     if ((c == uld_pkg::CHAR_SLASH) || (host_len == 5'd0)) begin
                        mode_in  = uld_pkg::MODE_BODY;
                        run_body = 1'b1;
                     end else begin
                        mode_in  = uld_pkg::MODE_HOST;
                        run_host = 1'b1;
                     end
                  end
               end
               uld_pkg::MODE_HOST: run_host = 1'b1;
               default:            run_body = 1'b1;
            endcase
         end
      end

      if (run_host) begin
         hbyte = match_in[4] ? 8'h00 : host_all[{match_in[3:0], 3'b000} +: 8];
         if (c == hbyte) begin
            match_in = 5'(match_in + 5'd1);
            if (match_in >= host_len) mode_in = uld_pkg::MODE_BODY;
         end else begin
            mode_in = uld_pkg::MODE_SKIP;
         end
      end

      if (run_body) begin
         case (mode_in)
            uld_pkg::MODE_BODY: begin
               if (c == uld_pkg::CHAR_PERCENT) mode_in = uld_pkg::MODE_ESC1;
               else evt.has_byte = 1'b1;
            end
            uld_pkg::MODE_ESC1: begin
               if (!hx[4]) begin
                  mode_in = uld_pkg::MODE_SKIP;
               end else begin
                  hex_in  = hx[3:0];
                  mode_in = uld_pkg::MODE_ESC2;
               end
            end
            uld_pkg::MODE_ESC2: begin
               if (!hx[4]) begin
                  mode_in = uld_pkg::MODE_SKIP;
               end else begin
                  evt.has_byte = 1'b1;
                  evt.byte_val = {hex_in, hx[3:0]};
                  mode_in      = uld_pkg::MODE_BODY;
               end
            end
            default: ;
         endcase
      end

      // close the URI on whitespace or at the end of the buffer
      if (run_end || req_buffer_end) begin
         pm = match_in[2:0];
         case (mode_in)
            uld_pkg::MODE_IDLE: ;
            uld_pkg::MODE_BODY: evt.has_end = 1'b1;
            uld_pkg::MODE_PREFIX: begin
               evt.has_end = 1'b1;
               if (pm < 3'd6) begin
                  evt.pre_start = 3'd0;
                  evt.pre_cnt   = pm;
               end else if (pm == 3'd6) begin
                  evt.pre_start = 3'd5;
                  evt.pre_cnt   = 3'd1;
               end else begin
                  evt.end_reject = (host_len != 5'd0);
               end
            end
            default: begin
               evt.has_end    = 1'b1;
               evt.end_reject = 1'b1;
            end
         endcase
         mode_in  = uld_pkg::MODE_IDLE;
         match_in = 5'd0;
         hex_in   = 4'd0;
      end
   end

   // result group for the queue
   always_comb begin
      grp_new.pre_start  = evt.pre_start;
      grp_new.pre_cnt    = evt.pre_cnt;
      grp_new.has_byte   = evt.has_byte;
      grp_new.byte_val   = evt.byte_val;
      grp_new.end_reject = evt.end_reject;
      grp_new.total      = evt.pre_cnt + {2'b00, evt.has_byte} + {2'b00, evt.has_end};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= uld_pkg::MODE_IDLE;
         match_ff <= '0;
         hex_ff   <= '0;
      end else if (req_xfer) begin
         mode_ff  <= mode_in;
         match_ff <= match_in;
         hex_ff   <= hex_in;
      end
   end

   // result group queue
   assign head = grp_ff[rd_ptr_ff];
   assign push = req_xfer && (grp_new.total != 3'd0);
   assign pop  = rsp_xfer && rsp_run_last;

   always_ff @(posedge clock) begin
      if (push) grp_ff[wr_ptr_ff] <= grp_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         pos_ff    <= 3'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
         if (pop) pos_ff <= 3'd0;
         else if (rsp_xfer) pos_ff <= pos_ff + 3'd1;
      end
   end

   // item selection within the head group
   always_comb begin
      rsp_run_last = (pos_ff == head.total - 3'd1);
      if (pos_ff < head.pre_cnt) begin
         rsp_result_kind  = uld_pkg::KIND_BYTE;
         rsp_decoded_byte = uld_pkg::prefix_char(head.pre_start + pos_ff);
      end else if ((pos_ff == head.pre_cnt) && head.has_byte) begin
         rsp_result_kind  = uld_pkg::KIND_BYTE;
         rsp_decoded_byte = head.byte_val;
      end else begin
         rsp_result_kind  = head.end_reject ? uld_pkg::KIND_REJECT : uld_pkg::KIND_ACCEPT;
         rsp_decoded_byte = 8'h00;
      end
   end

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_pos_in_group, (cnt_ff == 2'd0) || (pos_ff < head.total), "bad item index")
   `ASSERT_ALWAYS(a_prefix_match, mode_ff != uld_pkg::MODE_PREFIX || match_ff < 5'd8, "bad prefix")
   `ASSERT_ALWAYS(a_queue_depth, cnt_ff <= 2'd2, "result queue overflow")
   `ASSERT_NEXT(a_end_idle, req_xfer && req_buffer_end, mode_ff == uld_pkg::MODE_IDLE, "open URI")

endmodule
